[hdl/pftau_pkg.sv]
// Shared constants, types and helper functions of the perspective floor texel address unit.
`default_nettype none

package pftau_pkg;

	// screen geometry
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int HORIZON       = SCREEN_HEIGHT / 2;
	localparam int CENTER        = SCREEN_WIDTH / 2;

	// field widths
	localparam int SX_W   = 9;
	localparam int SY_W   = 8;
	localparam int POS_W  = 24;
	localparam int TRIG_W = 16;
	localparam int MAP_W  = 13;
	localparam int TEX_W  = 12;

	// fixed point
	localparam int POS_FRAC   = 8;
	localparam int TRIG_FRAC  = 14;
	localparam int FRAC_SHIFT = POS_FRAC + TRIG_FRAC;
	localparam int MAP_LIMIT  = 4096;
	localparam logic [MAP_W-1:0] MAP_LIMIT_C = MAP_W'(MAP_LIMIT);

	// coordinate arithmetic, wide enough for any screen size in range
	localparam int COORD_W = 13;
	localparam int DXF_W   = COORD_W + 1;
	localparam logic [COORD_W-1:0] HORIZON_C = COORD_W'(HORIZON);
	localparam logic [COORD_W-1:0] CENTER_C  = COORD_W'(CENTER);
	localparam int SX_MAX  = (1 << SX_W) - 1;
	localparam int ADX_MAX = (CENTER > SX_MAX - CENTER) ? CENTER : SX_MAX - CENTER;
	localparam int ADX_W   = $clog2(ADX_MAX + 1);
	localparam int DY_W    = SY_W;

	// divider: quotient bits and bits retired per stage
	localparam int DIV_W      = 2 * POS_W - POS_FRAC;
	localparam int DIV_STEP   = 8;
	localparam int DIV_STAGES = DIV_W / DIV_STEP;

	// rotation and sum widths
	localparam int ROT_W  = DIV_W + 1;
	localparam int PROD_W = ROT_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int TW     = SUM_W - 1 - FRAC_SHIFT;

	// front, divider stages, multiply, sum, output
	localparam int PIPE_DEPTH = DIV_STAGES + 4;
	localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

	// register file
	localparam int REG_COUNT = 8;
	localparam int ADDR_W    = $clog2(REG_COUNT) + 2;
	localparam int DATA_W    = 32;

	typedef enum logic [2:0] {
		REG_FOCAL      = 3'd0,
		REG_HEIGHT     = 3'd1,
		REG_CAM_X      = 3'd2,
		REG_CAM_Z      = 3'd3,
		REG_COS        = 3'd4,
		REG_SIN        = 3'd5,
		REG_MAP_WIDTH  = 3'd6,
		REG_MAP_HEIGHT = 3'd7
	} reg_idx_t;

	localparam logic [POS_W-1:0]  FOCAL_RST  = POS_W'(53203);
	localparam logic [POS_W-1:0]  HEIGHT_RST = POS_W'(2560);
	localparam logic [TRIG_W-1:0] COS_RST    = TRIG_W'(16384);
	localparam logic [MAP_W-1:0]  MAP_RST    = MAP_W'(1024);

	typedef struct packed {
		logic        [POS_W-1:0]  focal_distance;
		logic        [POS_W-1:0]  camera_height;
		logic signed [POS_W-1:0]  camera_x;
		logic signed [POS_W-1:0]  camera_z;
		logic signed [TRIG_W-1:0] cos_heading;
		logic signed [TRIG_W-1:0] sin_heading;
		logic        [MAP_W-1:0]  map_width;
		logic        [MAP_W-1:0]  map_height;
	} cfg_t;

	typedef struct packed {
		logic row_ok;
		logic dx_neg;
	} side_t;

	// one divider lane: partial remainder and dividend/quotient shift word
	typedef struct packed {
		logic [DY_W-1:0]  rem;
		logic [DIV_W-1:0] word;
	} div_lane_t;

	typedef struct packed {
		side_t           side;
		logic [DY_W-1:0] divisor;
		div_lane_t       depth;
		div_lane_t       lat;
	} div_item_t;

	typedef struct packed {
		logic                    row_ok;
		logic signed [SUM_W-1:0] wx;
		logic signed [SUM_W-1:0] wy;
	} sum_t;

	// DIV_STEP restoring division steps; quotient bits enter the word at the bottom
	function automatic div_lane_t div_steps(input div_lane_t x, input logic [DY_W-1:0] d);
		div_lane_t     r;
		logic [DY_W:0] t;
		logic          ge;
		r = x;
		for (int i = 0; i < DIV_STEP; i++) begin
			t      = {r.rem, r.word[DIV_W-1]};
			ge     = (t >= {1'b0, d});
			r.rem  = ge ? DY_W'(t - {1'b0, d}) : t[DY_W-1:0];
			r.word = {r.word[DIV_W-2:0], ge};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/perspective_floor_texel_address_unit.sv]
// The 9 stages are the front multiply, 5 divider stages (8 quotient bits each), rotation
// products, position sums and the result register; the 40-bit divider sets the depth.
// Throughput: one request per clock; every stage holds its item on back-pressure and fills
// bubbles. Reset (arst_n low) empties the pipeline and loads the register defaults.
`default_nettype none

module perspective_floor_texel_address_unit
	import pftau_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [23:0]       s_tdata,  // [8:0] screen_x, [16:9] screen_y, [23:17] zero
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [23:0]       m_tdata,  // [11:0] texel_x, [23:12] texel_y
	output logic                   m_tuser,  // [0] outside
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t             cfg;
	logic             div_v [DIV_STAGES+1];
	logic             div_r [DIV_STAGES+1];
	div_item_t        div_item [DIV_STAGES+1];
	logic             sum_v;
	logic             sum_r;
	sum_t             sum;
	logic [TEX_W-1:0] texel_x;
	logic [TEX_W-1:0] texel_y;
	logic             outside;
	logic [OCC_W-1:0] occ_q;
	logic             in_fire;
	logic             out_fire;

	// camera and map registers; user keeps them fixed with requests in flight; not enforced
	pftau_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// horizon test, offsets, F*H and H*|dx|
	pftau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.screen_x  (s_tdata[SX_W-1:0]),
		.screen_y  (s_tdata[SX_W+SY_W-1:SX_W]),
		.out_valid (div_v[0]),
		.out_ready (div_r[0]),
		.out_item  (div_item[0])
	);

	// pipelined restoring divider, both lanes divided by the row distance
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		pftau_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_v[g]),
			.in_ready  (div_r[g]),
			.in_item   (div_item[g]),
			.out_valid (div_v[g+1]),
			.out_ready (div_r[g+1]),
			.out_item  (div_item[g+1])
		);
	end

	// rotate by heading and add camera position
	pftau_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (div_v[DIV_STAGES]),
		.in_ready  (div_r[DIV_STAGES]),
		.in_item   (div_item[DIV_STAGES]),
		.out_valid (sum_v),
		.out_ready (sum_r),
		.out_sum   (sum)
	);

	// texel truncation, bounds and result register
	pftau_texel u_texel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sum_v),
		.in_ready  (sum_r),
		.in_sum    (sum),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.texel_x   (texel_x),
		.texel_y   (texel_y),
		.outside   (outside)
	);

	assign m_tdata = {texel_y, texel_x};
	assign m_tuser = outside;

	// requests in flight, for the checks below
	assign in_fire  = s_tvalid & s_tready;
	assign out_fire = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_fire, out_fire})
				2'b10:   occ_q <= occ_q + OCC_W'(1);
				2'b01:   occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !m_tvalid)
		else $error("result presented with no request in flight");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("outside result carries nonzero texel");

endmodule

`default_nettype wire

[hdl/pftau_cfg.sv]
// APB register file holding the camera and map configuration.
`default_nettype none

module pftau_cfg
	import pftau_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_distance <= FOCAL_RST;
			cfg_q.camera_height  <= HEIGHT_RST;
			cfg_q.camera_x       <= '0;
			cfg_q.camera_z       <= '0;
			cfg_q.cos_heading    <= COS_RST;
			cfg_q.sin_heading    <= '0;
			cfg_q.map_width      <= MAP_RST;
			cfg_q.map_height     <= MAP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_FOCAL:      cfg_q.focal_distance <= pwdata[POS_W-1:0];
				REG_HEIGHT:     cfg_q.camera_height  <= pwdata[POS_W-1:0];
				REG_CAM_X:      cfg_q.camera_x       <= pwdata[POS_W-1:0];
				REG_CAM_Z:      cfg_q.camera_z       <= pwdata[POS_W-1:0];
				REG_COS:        cfg_q.cos_heading    <= pwdata[TRIG_W-1:0];
				REG_SIN:        cfg_q.sin_heading    <= pwdata[TRIG_W-1:0];
				REG_MAP_WIDTH:  cfg_q.map_width      <= pwdata[MAP_W-1:0];
				REG_MAP_HEIGHT: cfg_q.map_height     <= pwdata[MAP_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FOCAL:      prdata = DATA_W'(cfg_q.focal_distance);
			REG_HEIGHT:     prdata = DATA_W'(cfg_q.camera_height);
			REG_CAM_X:      prdata = DATA_W'($unsigned(cfg_q.camera_x));
			REG_CAM_Z:      prdata = DATA_W'($unsigned(cfg_q.camera_z));
			REG_COS:        prdata = DATA_W'($unsigned(cfg_q.cos_heading));
			REG_SIN:        prdata = DATA_W'($unsigned(cfg_q.sin_heading));
			REG_MAP_WIDTH:  prdata = DATA_W'(cfg_q.map_width);
			REG_MAP_HEIGHT: prdata = DATA_W'(cfg_q.map_height);
		endcase
	end

endmodule

`default_nettype wire

[hdl/pftau_front.sv]
// Front stage: row and column offsets and the two divider dividends.
`default_nettype none

module pftau_front
	import pftau_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cfg_t            cfg,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [SX_W-1:0] screen_x,
	input  wire logic [SY_W-1:0] screen_y,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output div_item_t            out_item
);

	logic                      valid_s1;
	div_item_t                 item_s1;
	div_item_t                 item_d;
	logic                      row_ok;
	logic        [DY_W-1:0]    dy;
	logic signed [DXF_W-1:0]   dx_full;
	logic        [DXF_W-1:0]   dx_mag;
	logic        [ADX_W-1:0]   adx;
	logic        [2*POS_W-1:0] prod_fh;
	logic [POS_W+ADX_W-1:0]    prod_hx;

	assign row_ok  = COORD_W'(screen_y) > HORIZON_C;
	assign dy      = DY_W'(COORD_W'(screen_y) - HORIZON_C);
	assign dx_full = $signed({1'b0, COORD_W'(screen_x)}) - $signed({1'b0, CENTER_C});
	assign dx_mag  = dx_full[DXF_W-1] ? DXF_W'(-dx_full) : DXF_W'(dx_full);
	assign adx     = dx_mag[ADX_W-1:0];
	assign prod_fh = cfg.focal_distance * cfg.camera_height;
	assign prod_hx = cfg.camera_height * adx;

	always_comb begin
		item_d.side.row_ok = row_ok;
		item_d.side.dx_neg = dx_full[DXF_W-1];
		item_d.divisor     = dy;
		item_d.depth.rem   = '0;
		item_d.depth.word  = prod_fh[2*POS_W-1:POS_FRAC];
		item_d.lat.rem     = '0;
		item_d.lat.word    = DIV_W'(prod_hx);
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

[hdl/pftau_div_stage.sv]
// One divider stage: DIV_STEP restoring steps on the depth and lateral lanes.
`default_nettype none

module pftau_div_stage
	import pftau_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire div_item_t in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output div_item_t      out_item
);

	// _sn: register of this divider stage
	logic      valid_sn;
	div_item_t item_sn;
	div_item_t item_d;

	always_comb begin
		item_d       = in_item;
		item_d.depth = div_steps(in_item.depth, in_item.divisor);
		item_d.lat   = div_steps(in_item.lat, in_item.divisor);
	end

	assign in_ready  = !valid_sn || out_ready;
	assign out_valid = valid_sn;
	assign out_item  = item_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (in_ready) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_sn <= item_d;
		end
	end

endmodule

`default_nettype wire

[hdl/pftau_rotate.sv]
// Heading rotation: four registered products, then the position sums.
`default_nettype none

module pftau_rotate
	import pftau_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire div_item_t in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output sum_t           out_sum
);

	logic                     valid_s7;
	logic                     valid_s8;
	logic                     row_ok_s7;
	logic signed [PROD_W-1:0] p_lc_s7;
	logic signed [PROD_W-1:0] p_ds_s7;
	logic signed [PROD_W-1:0] p_ls_s7;
	logic signed [PROD_W-1:0] p_dc_s7;
	sum_t                     sum_s8;
	logic                     ready_s8;
	logic signed [ROT_W-1:0]  lat;
	logic signed [ROT_W-1:0]  depth;
	logic signed [PROD_W-1:0] p_lc;
	logic signed [PROD_W-1:0] p_ds;
	logic signed [PROD_W-1:0] p_ls;
	logic signed [PROD_W-1:0] p_dc;
	logic signed [SUM_W-1:0]  cam_x_w;
	logic signed [SUM_W-1:0]  cam_z_w;
	sum_t                     sum_d;

	assign depth = $signed({1'b0, in_item.depth.word});
	assign lat   = in_item.side.dx_neg ? -$signed({1'b0, in_item.lat.word})
	                                   : $signed({1'b0, in_item.lat.word});

	assign p_lc = lat * cfg.cos_heading;
	assign p_ds = depth * cfg.sin_heading;
	assign p_ls = lat * cfg.sin_heading;
	assign p_dc = depth * cfg.cos_heading;

	// camera position widened to Q.22
	assign cam_x_w = SUM_W'(cfg.camera_x) <<< TRIG_FRAC;
	assign cam_z_w = SUM_W'(cfg.camera_z) <<< TRIG_FRAC;

	always_comb begin
		sum_d.row_ok = row_ok_s7;
		sum_d.wx     = cam_x_w + p_lc_s7 + p_ds_s7;
		sum_d.wy     = cam_z_w + p_ls_s7 - p_dc_s7;
	end

	assign ready_s8  = !valid_s8 || out_ready;
	assign in_ready  = !valid_s7 || ready_s8;
	assign out_valid = valid_s8;
	assign out_sum   = sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s7 <= in_valid;
			end
			if (ready_s8) begin
				valid_s8 <= valid_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			row_ok_s7 <= in_item.side.row_ok;
			p_lc_s7   <= p_lc;
			p_ds_s7   <= p_ds;
			p_ls_s7   <= p_ls;
			p_dc_s7   <= p_dc;
		end
		if (ready_s8 && valid_s7) begin
			sum_s8 <= sum_d;
		end
	end

endmodule

`default_nettype wire

[hdl/pftau_texel.sv]
// Output stage: truncation to texels, map bounds check, result register.
`default_nettype none

module pftau_texel
	import pftau_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sum_t             in_sum,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [TEX_W-1:0] texel_x,
	output logic      [TEX_W-1:0] texel_y,
	output logic                  outside
);

	logic             valid_s9;
	logic [TEX_W-1:0] texel_x_s9;
	logic [TEX_W-1:0] texel_y_s9;
	logic             outside_s9;
	logic [TW-1:0]    tx;
	logic [TW-1:0]    ty;
	logic [MAP_W-1:0] lim_x;
	logic [MAP_W-1:0] lim_y;
	logic             ok_x;
	logic             ok_y;
	logic             ok;

	assign tx    = in_sum.wx[SUM_W-2:FRAC_SHIFT];
	assign ty    = in_sum.wy[SUM_W-2:FRAC_SHIFT];
	// maps larger than the texel range in either dimension clamp to it
	assign lim_x = (cfg.map_width > MAP_LIMIT_C) ? MAP_LIMIT_C : cfg.map_width;
	assign lim_y = (cfg.map_height > MAP_LIMIT_C) ? MAP_LIMIT_C : cfg.map_height;
	assign ok_x  = !in_sum.wx[SUM_W-1] && (tx < TW'(lim_x));
	assign ok_y  = !in_sum.wy[SUM_W-1] && (ty < TW'(lim_y));
	assign ok    = in_sum.row_ok && ok_x && ok_y;

	assign in_ready  = !valid_s9 || out_ready;
	assign out_valid = valid_s9;
	assign texel_x   = texel_x_s9;
	assign texel_y   = texel_y_s9;
	assign outside   = outside_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (in_ready) begin
			valid_s9 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			texel_x_s9 <= ok ? tx[TEX_W-1:0] : '0;
			texel_y_s9 <= ok ? ty[TEX_W-1:0] : '0;
			outside_s9 <= !ok;
		end
	end

endmodule

`default_nettype wire
